/* rtl/conv5_pkg.sv */
// Shared types, sizes and weight tables for the 5x5 smoothing/blur filter.
// Used by conv5x5_smooth_blur_filter; no dependencies.
package conv5_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 11;
    localparam int ROW_BITS    = 16;
    localparam int LINES       = 4;
    localparam int TAPS        = 5;
    localparam int MIN_DIM     = 5;

    localparam int WEIGHT_BITS = 14;
    localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
    localparam int ROW_SUM_BITS = PROD_BITS + 3;
    localparam int ACC_BITS    = ROW_SUM_BITS + 3;
    localparam int FRAC_BITS   = 16;
    localparam int Y_BITS      = ACC_BITS - FRAC_BITS;

    // configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE = 2'd2;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(MIN_DIM);

    localparam logic MODE_BOX   = 1'b0;
    localparam logic MODE_GAUSS = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LINES-1:0][SAMPLE_BITS-1:0] line_word_t;

    // unsigned Q0.16 weights
    localparam logic [WEIGHT_BITS-1:0] BOX_W = 14'd2621;
    localparam logic [WEIGHT_BITS-1:0] GAUSS_W [TAPS][TAPS] = '{
        '{14'd191,  14'd856,  14'd1412,  14'd856,  14'd191},
        '{14'd856,  14'd3837, 14'd6326,  14'd3837, 14'd856},
        '{14'd1412, 14'd6326, 14'd10430, 14'd6326, 14'd1412},
        '{14'd856,  14'd3837, 14'd6326,  14'd3837, 14'd856},
        '{14'd191,  14'd856,  14'd1412,  14'd856,  14'd191}
    };

endpackage

/* rtl/conv5x5_smooth_blur_filter.sv */
// 5x5 box / Gaussian convolution over a raster-order sample stream.
// Depends on conv5_pkg for sizes, types and weight tables.
//
// Usage:
//   Samples enter on the s_* stream, one signed 16-bit value per transaction,
//   row by row. Results leave on the m_* stream, one per interior window
//   centre (two-sample border is dropped); m_tlast marks the final interior
//   result of a grid. Geometry and mode are to be set through cfg_we/
//   cfg_index/cfg_data only while the block is idle, which the block itself
//   does not enforce; writes take effect at once. Throughput: one sample per
//   clock unless stalled. Before m_tvalid, a result passes line-store read,
//   window shift, 25 parallel multiplies, row sums, final add/round/saturate.
//   Four line stores share one 1024 x 64-bit memory (one lane per row slot),
//   read and lane-written at the same column address in the accept cycle.
//   Reset clears counters, window and pipeline valids and loads width 1024,
//   height 5, box mode; the line memory is not cleared. When the receiver
//   holds m_tready low with a result pending, the whole pipeline stalls and
//   s_tready drops in the same cycle.
module conv5x5_smooth_blur_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] filtered, [25:16] center_col,
                                   // [41:26] center_row, [47:42] zero
    output logic        m_tlast,   // last_of_grid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SB = conv5_pkg::SAMPLE_BITS;
    localparam int CB = conv5_pkg::COL_BITS;
    localparam int WB = conv5_pkg::WIDTH_BITS;
    localparam int RB = conv5_pkg::ROW_BITS;
    localparam int NT = conv5_pkg::TAPS;

    // configuration
    logic [WB-1:0] grid_width_reg;
    logic [RB-1:0] grid_height_reg;
    logic          filter_mode_reg;

    // counters
    logic [CB-1:0] col_reg;
    logic [RB-1:0] row_reg;

    // line memory
    conv5_pkg::line_word_t line_mem [conv5_pkg::MAX_WIDTH];
    conv5_pkg::line_word_t rd_reg;

    // stage 1
    logic                 v1_reg;
    logic                 emit1_reg;
    conv5_pkg::sample_t   sample1_reg;
    logic [1:0]           slot1_reg;
    logic [CB-1:0]        ccol1_reg;
    logic [RB-1:0]        crow1_reg;
    logic                 last1_reg;

    // window, stage 2
    conv5_pkg::sample_t   win_reg [NT][NT];
    logic                 v2_reg;
    logic [CB-1:0]        ccol2_reg;
    logic [RB-1:0]        crow2_reg;
    logic                 last2_reg;

    // products, stage 3
    logic signed [conv5_pkg::PROD_BITS-1:0] prod_reg [NT][NT];
    logic                 v3_reg;
    logic [CB-1:0]        ccol3_reg;
    logic [RB-1:0]        crow3_reg;
    logic                 last3_reg;

    // row sums, stage 4
    logic signed [conv5_pkg::ROW_SUM_BITS-1:0] rsum_reg [NT];
    logic                 v4_reg;
    logic [CB-1:0]        ccol4_reg;
    logic [RB-1:0]        crow4_reg;
    logic                 last4_reg;

    // output
    logic                 out_valid_reg;
    conv5_pkg::sample_t   out_filt_reg;
    logic [CB-1:0]        out_col_reg;
    logic [RB-1:0]        out_row_reg;
    logic                 out_last_reg;

    logic          adv;
    logic          accept;
    logic [WB-1:0] w_eff;
    logic [RB-1:0] h_eff;
    logic [CB-1:0] col_eff;
    logic          row_end;
    logic          grid_end;
    logic          emit;
    logic          last_now;
    logic [CB-1:0] col_next;
    logic [RB-1:0] row_next;

    conv5_pkg::sample_t column [NT];

    logic signed [conv5_pkg::ACC_BITS-1:0] acc;
    logic signed [conv5_pkg::ACC_BITS-1:0] biased;
    logic signed [conv5_pkg::Y_BITS-1:0]   y;
    conv5_pkg::sample_t                    y_sat;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // effective geometry: width clamped to [5, MAX_WIDTH], height to >= 5
    always_comb
    begin
        priority if (grid_width_reg < WB'(conv5_pkg::MIN_DIM))
            w_eff = WB'(conv5_pkg::MIN_DIM);
        else if (grid_width_reg > WB'(conv5_pkg::MAX_WIDTH))
            w_eff = WB'(conv5_pkg::MAX_WIDTH);
        else
            w_eff = grid_width_reg;

        if (grid_height_reg < RB'(conv5_pkg::MIN_DIM))
            h_eff = RB'(conv5_pkg::MIN_DIM);
        else
            h_eff = grid_height_reg;

        // column past the last one (width shrunk) folds onto the last column
        if ({1'b0, col_reg} >= w_eff)
            col_eff = CB'(w_eff - WB'(1));
        else
            col_eff = col_reg;

        row_end  = ({1'b0, col_eff} + WB'(1)) >= w_eff;
        grid_end = ({1'b0, row_reg} + (RB+1)'(1)) >= {1'b0, h_eff};
        emit     = (row_reg >= RB'(4)) && (col_eff >= CB'(4));
        last_now = (row_reg == h_eff - RB'(1)) && ({1'b0, col_eff} == w_eff - WB'(1));

        if (row_end)
        begin
            col_next = '0;
            row_next = grid_end ? '0 : row_reg + RB'(1);
        end
        else
        begin
            col_next = col_eff + CB'(1);
            row_next = row_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= conv5_pkg::WIDTH_RESET;
            grid_height_reg <= conv5_pkg::HEIGHT_RESET;
            filter_mode_reg <= conv5_pkg::MODE_BOX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                conv5_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[WB-1:0];
                conv5_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data[RB-1:0];
                conv5_pkg::REG_FILTER_MODE: filter_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: read all four lanes, overwrite the oldest row's lane
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= line_mem[col_eff];
            line_mem[col_eff][row_reg[1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample1_reg <= s_tdata;
            slot1_reg   <= row_reg[1:0];
            emit1_reg   <= emit;
            ccol1_reg   <= col_eff - CB'(2);
            crow1_reg   <= row_reg - RB'(2);
            last1_reg   <= last_now;
        end
    end

    // oldest row first: lanes starting at the slot being overwritten
    always_comb
    begin
        for (int r = 0; r < NT - 1; r++)
            column[r] = rd_reg[2'(slot1_reg + 2'(r))];
        column[NT-1] = sample1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NT; r++)
                for (int c = 0; c < NT; c++)
                    win_reg[r][c] <= '0;
        end
        else if (adv && v1_reg)
        begin
            for (int r = 0; r < NT; r++)
            begin
                for (int c = 0; c < NT - 1; c++)
                    win_reg[r][c] <= win_reg[r][c+1];
                win_reg[r][NT-1] <= column[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ccol2_reg <= ccol1_reg;
            crow2_reg <= crow1_reg;
            last2_reg <= last1_reg;
            ccol3_reg <= ccol2_reg;
            crow3_reg <= crow2_reg;
            last3_reg <= last2_reg;
            ccol4_reg <= ccol3_reg;
            crow4_reg <= crow3_reg;
            last4_reg <= last3_reg;

            for (int r = 0; r < NT; r++)
                for (int c = 0; c < NT; c++)
                    prod_reg[r][c] <= win_reg[r][c] * $signed({1'b0,
                        (filter_mode_reg == conv5_pkg::MODE_GAUSS) ?
                        conv5_pkg::GAUSS_W[r][c] : conv5_pkg::BOX_W});

            for (int r = 0; r < NT; r++)
                rsum_reg[r] <= conv5_pkg::ROW_SUM_BITS'(prod_reg[r][0])
                             + conv5_pkg::ROW_SUM_BITS'(prod_reg[r][1])
                             + conv5_pkg::ROW_SUM_BITS'(prod_reg[r][2])
                             + conv5_pkg::ROW_SUM_BITS'(prod_reg[r][3])
                             + conv5_pkg::ROW_SUM_BITS'(prod_reg[r][4]);
        end
    end

    // final sum, round half up, saturate
    always_comb
    begin
        acc = '0;
        for (int r = 0; r < NT; r++)
            acc = acc + conv5_pkg::ACC_BITS'(rsum_reg[r]);
        biased = acc + conv5_pkg::ACC_BITS'(1 << (conv5_pkg::FRAC_BITS - 1));
        y      = biased[conv5_pkg::ACC_BITS-1:conv5_pkg::FRAC_BITS];
        priority if (y > conv5_pkg::Y_BITS'(conv5_pkg::OUT_MAX))
            y_sat = conv5_pkg::OUT_MAX;
        else if (y < conv5_pkg::Y_BITS'(conv5_pkg::OUT_MIN))
            y_sat = conv5_pkg::OUT_MIN;
        else
            y_sat = y[SB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_filt_reg <= y_sat;
            out_col_reg  <= ccol4_reg;
            out_row_reg  <= crow4_reg;
            out_last_reg <= last4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg && emit1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_row_reg, out_col_reg, out_filt_reg};
    assign m_tlast  = out_last_reg;

endmodule
